// ----- rtl/core/ryp_pkg.sv -----
// Shared constants and types for the RGB to YUV 4:2:0 planar converter.
`default_nettype none

package ryp_pkg;

    // Frame size limits, in pixel pairs and row pairs
    localparam int unsigned MAX_HALF_WIDTH  = 1024;
    localparam int unsigned MAX_HALF_HEIGHT = 1024;

    // Field widths
    localparam int unsigned CHAN_W   = 8;
    localparam int unsigned SIZE_W   = 11;
    localparam int unsigned DIM_W    = SIZE_W + 1;
    localparam int unsigned LIDX_W   = 22;
    localparam int unsigned CIDX_W   = 20;
    localparam int unsigned CFG_IDX_W = 2;

    // Weighted sums stay below 2^15; one spare bit keeps the modular math clean
    localparam int unsigned SUM_W  = 16;
    localparam int unsigned PROD_W = 30;

    // Color matrix coefficients (percent)
    localparam logic [SUM_W-1:0] COEF_Y_R = 16'd30;
    localparam logic [SUM_W-1:0] COEF_Y_G = 16'd59;
    localparam logic [SUM_W-1:0] COEF_Y_B = 16'd11;
    localparam logic [SUM_W-1:0] COEF_U_R = 16'd17;
    localparam logic [SUM_W-1:0] COEF_U_G = 16'd33;
    localparam logic [SUM_W-1:0] COEF_U_B = 16'd50;
    localparam logic [SUM_W-1:0] COEF_V_R = 16'd50;
    localparam logic [SUM_W-1:0] COEF_V_G = 16'd42;
    localparam logic [SUM_W-1:0] COEF_V_B = 16'd8;
    localparam logic [SUM_W-1:0] CHROMA_OFFSET = 16'd12800;

    // Divide by 100: (x * 5243) >> 19 is exact for x below 43690
    localparam logic [PROD_W-1:0] RECIP_100   = 30'd5243;
    localparam int unsigned       RECIP_SHIFT = 19;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HALF_WIDTH  = 2'd0,
        CFG_HALF_HEIGHT = 2'd1,
        CFG_FLIP_ROWS   = 2'd2
    } cfg_index_t;

    // Per-stage load strobes for the color pipeline
    typedef struct packed {
        logic sum_en;
        logic scale_en;
    } csc_adv_t;

endpackage

`default_nettype wire

// ----- rtl/core/ryp_csc.sv -----
// Two-stage color matrix: weighted sums, then divide by 100 via reciprocal.
`default_nettype none

module ryp_csc (
    input  wire logic                       aclk,
    input  wire ryp_pkg::csc_adv_t          adv,
    input  wire logic [ryp_pkg::CHAN_W-1:0] red,
    input  wire logic [ryp_pkg::CHAN_W-1:0] green,
    input  wire logic [ryp_pkg::CHAN_W-1:0] blue,
    output logic      [ryp_pkg::CHAN_W-1:0] y_out,
    output logic      [ryp_pkg::CHAN_W-1:0] u_out,
    output logic      [ryp_pkg::CHAN_W-1:0] v_out
);
    import ryp_pkg::*;

    logic [SUM_W-1:0]  r_ext, g_ext, b_ext;
    logic [SUM_W-1:0]  y_sum_next, u_sum_next, v_sum_next;
    logic [SUM_W-1:0]  y_sum_reg, u_sum_reg, v_sum_reg;
    logic [PROD_W-1:0] y_prod, u_prod, v_prod;

    assign r_ext = {{(SUM_W-CHAN_W){1'b0}}, red};
    assign g_ext = {{(SUM_W-CHAN_W){1'b0}}, green};
    assign b_ext = {{(SUM_W-CHAN_W){1'b0}}, blue};

    // Form the three weighted sums; chroma sums never go negative overall
    always_comb begin
        y_sum_next = COEF_Y_R * r_ext + COEF_Y_G * g_ext + COEF_Y_B * b_ext;
        u_sum_next = CHROMA_OFFSET + COEF_U_B * b_ext - COEF_U_R * r_ext - COEF_U_G * g_ext;
        v_sum_next = CHROMA_OFFSET + COEF_V_R * r_ext - COEF_V_G * g_ext - COEF_V_B * b_ext;
    end

    always_ff @(posedge aclk) begin
        if (adv.sum_en) begin
            y_sum_reg <= y_sum_next;
            u_sum_reg <= u_sum_next;
            v_sum_reg <= v_sum_next;
        end
    end

    // Truncating divide by 100
    assign y_prod = {{(PROD_W-SUM_W){1'b0}}, y_sum_reg} * RECIP_100;
    assign u_prod = {{(PROD_W-SUM_W){1'b0}}, u_sum_reg} * RECIP_100;
    assign v_prod = {{(PROD_W-SUM_W){1'b0}}, v_sum_reg} * RECIP_100;

    always_ff @(posedge aclk) begin
        if (adv.scale_en) begin
            y_out <= y_prod[RECIP_SHIFT +: CHAN_W];
            u_out <= u_prod[RECIP_SHIFT +: CHAN_W];
            v_out <= v_prod[RECIP_SHIFT +: CHAN_W];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/rgb_to_yuv420_planar.sv -----
// Top level of the RGB to YUV 4:2:0 planar converter.
//
// Takes one RGB pixel per transaction in source raster order and returns one result per
// pixel: the Y sample with its Y-plane index, and at the odd column of each odd output row
// the U and V samples with their chroma-plane index (zero otherwise). Throughput is one
// pixel per clock while m_ready does not stall the output, through the three-register
// pipeline (input register; weighted sums and index products; divide-by-100 and result
// register). Each stage fills a bubble ahead of it, so while a result waits on m_ready
// the input keeps accepting until all three stages hold a pixel. Frame size and row flip
// are written through the cfg_ port only while no pixel is in flight, a rule for the user
// that the block does not enforce; zero sizes act as one, oversized ones as the maximum.
`default_nettype none

module rgb_to_yuv420_planar (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // Configuration write port
    input  wire logic                            cfg_wr_en,
    input  wire logic [ryp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [ryp_pkg::SIZE_W-1:0]      cfg_wr_data,
    // Pixel input
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [ryp_pkg::CHAN_W-1:0]      s_red,
    input  wire logic [ryp_pkg::CHAN_W-1:0]      s_green,
    input  wire logic [ryp_pkg::CHAN_W-1:0]      s_blue,
    // Result output
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic      [ryp_pkg::CHAN_W-1:0]      m_luma_value,
    output logic      [ryp_pkg::LIDX_W-1:0]      m_luma_index,
    output logic                                 m_chroma_write,
    output logic      [ryp_pkg::CHAN_W-1:0]      m_u_value,
    output logic      [ryp_pkg::CHAN_W-1:0]      m_v_value,
    output logic      [ryp_pkg::CIDX_W-1:0]      m_chroma_index,
    output logic                                 m_frame_last
);
    import ryp_pkg::*;

    localparam logic [SIZE_W-1:0] HW_MAX = SIZE_W'(MAX_HALF_WIDTH);
    localparam logic [SIZE_W-1:0] HH_MAX = SIZE_W'(MAX_HALF_HEIGHT);
    localparam logic [SIZE_W-1:0] ONE    = SIZE_W'(1);

    // Configuration registers
    logic [SIZE_W-1:0] half_width_reg, half_height_reg;
    logic              flip_rows_reg;

    // Position counters
    logic [SIZE_W-1:0] column_count_reg, column_count_next;
    logic [SIZE_W-1:0] row_count_reg, row_count_next;

    // Stage 1: input register
    logic              p1_valid_reg;
    logic [CHAN_W-1:0] p1_red_reg, p1_green_reg, p1_blue_reg;
    logic [SIZE_W-1:0] p1_col_reg, p1_orow_reg, p1_hw_reg;
    logic              p1_last_reg;

    // Stage 2: index products
    logic              p2_valid_reg;
    logic [LIDX_W-1:0] p2_luma_base_reg;
    logic [CIDX_W-1:0] p2_chroma_base_reg;
    logic [SIZE_W-1:0] p2_col_reg;
    logic              p2_cw_reg, p2_last_reg;

    // Stage 3 payload
    logic [LIDX_W-1:0] luma_index_reg;
    logic              chroma_write_reg, frame_last_reg;
    logic [CIDX_W-1:0] chroma_index_reg;
    logic [CHAN_W-1:0] y_val, u_val, v_val;

    logic              m_valid_reg;
    logic              ready3, ready2, ld1, ld2, ld3;
    csc_adv_t          csc_adv;

    logic [SIZE_W-1:0] hw, hh;
    logic [DIM_W-1:0]  w, h;
    logic [DIM_W-1:0]  col_ext, row_try, row_sel, orow_full, col_inc;
    logic [SIZE_W-1:0] col_cur, row_cur, orow;
    logic              last;

    // Handshake: each stage loads when the stage after it can take its content
    assign ready3  = !m_valid_reg || m_ready;
    assign ready2  = !p2_valid_reg || ready3;
    assign s_ready = !p1_valid_reg || ready2;
    assign ld1     = s_valid && s_ready;
    assign ld2     = p1_valid_reg && ready2;
    assign ld3     = p2_valid_reg && ready3;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_width_reg  <= ONE;
            half_height_reg <= ONE;
            flip_rows_reg   <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_index_t'(cfg_index))
                CFG_HALF_WIDTH:  half_width_reg  <= cfg_wr_data;
                CFG_HALF_HEIGHT: half_height_reg <= cfg_wr_data;
                CFG_FLIP_ROWS:   flip_rows_reg   <= cfg_wr_data[0];
                default: ;
            endcase
        end
    end

    // Clamp sizes into the supported range
    always_comb begin
        hw = half_width_reg;
        if (half_width_reg == '0) begin
            hw = ONE;
        end else if (half_width_reg > HW_MAX) begin
            hw = HW_MAX;
        end
        hh = half_height_reg;
        if (half_height_reg == '0) begin
            hh = ONE;
        end else if (half_height_reg > HH_MAX) begin
            hh = HH_MAX;
        end
        w = {hw, 1'b0};
        h = {hh, 1'b0};
    end

    // Resolve the current pixel position and the counters for the next one
    always_comb begin
        col_ext = {1'b0, column_count_reg};
        row_try = {1'b0, row_count_reg};
        col_cur = column_count_reg;
        if (col_ext >= w) begin
            col_cur = '0;
            row_try = {1'b0, row_count_reg} + DIM_W'(1);
        end
        row_sel = (row_try >= h) ? '0 : row_try;
        row_cur = row_sel[SIZE_W-1:0];

        orow_full = flip_rows_reg ? (h - DIM_W'(1) - row_sel) : row_sel;
        orow      = orow_full[SIZE_W-1:0];

        last    = ({1'b0, col_cur} == w - DIM_W'(1)) && (row_sel == h - DIM_W'(1));
        col_inc = {1'b0, col_cur} + DIM_W'(1);

        if (last) begin
            column_count_next = '0;
            row_count_next    = '0;
        end else if (col_inc >= w) begin
            column_count_next = '0;
            row_count_next    = row_cur + ONE;
        end else begin
            column_count_next = col_inc[SIZE_W-1:0];
            row_count_next    = row_cur;
        end
    end

    // Advance the counters on each accepted pixel
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_count_reg <= '0;
            row_count_reg    <= '0;
        end else if (ld1) begin
            column_count_reg <= column_count_next;
            row_count_reg    <= row_count_next;
        end
    end

    // Valid bits of the pipeline
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s_ready) begin
                p1_valid_reg <= s_valid;
            end
            if (ready2) begin
                p2_valid_reg <= p1_valid_reg;
            end
            if (ready3) begin
                m_valid_reg <= p2_valid_reg;
            end
        end
    end

    // Stage 1: capture pixel and position
    always_ff @(posedge aclk) begin
        if (ld1) begin
            p1_red_reg   <= s_red;
            p1_green_reg <= s_green;
            p1_blue_reg  <= s_blue;
            p1_col_reg   <= col_cur;
            p1_orow_reg  <= orow;
            p1_hw_reg    <= hw;
            p1_last_reg  <= last;
        end
    end

    // Stage 2: row base addresses of both planes
    always_ff @(posedge aclk) begin
        if (ld2) begin
            p2_luma_base_reg   <= LIDX_W'(p1_orow_reg) * LIDX_W'({p1_hw_reg, 1'b0});
            p2_chroma_base_reg <= CIDX_W'(p1_orow_reg[SIZE_W-1:1]) * CIDX_W'(p1_hw_reg);
            p2_col_reg         <= p1_col_reg;
            p2_cw_reg          <= p1_orow_reg[0] && p1_col_reg[0];
            p2_last_reg        <= p1_last_reg;
        end
    end

    // Stage 3: final indexes into the result register
    always_ff @(posedge aclk) begin
        if (ld3) begin
            luma_index_reg   <= p2_luma_base_reg + LIDX_W'(p2_col_reg);
            chroma_index_reg <= p2_cw_reg ?
                                (p2_chroma_base_reg + CIDX_W'(p2_col_reg[SIZE_W-1:1])) : '0;
            chroma_write_reg <= p2_cw_reg;
            frame_last_reg   <= p2_last_reg;
        end
    end

    assign csc_adv.sum_en   = ld2;
    assign csc_adv.scale_en = ld3;

    ryp_csc u_csc (
        .aclk  (aclk),
        .adv   (csc_adv),
        .red   (p1_red_reg),
        .green (p1_green_reg),
        .blue  (p1_blue_reg),
        .y_out (y_val),
        .u_out (u_val),
        .v_out (v_val)
    );

    // Drive the result channel; chroma reads as zero when not written
    assign m_valid        = m_valid_reg;
    assign m_luma_value   = y_val;
    assign m_luma_index   = luma_index_reg;
    assign m_chroma_write = chroma_write_reg;
    assign m_u_value      = chroma_write_reg ? u_val : '0;
    assign m_v_value      = chroma_write_reg ? v_val : '0;
    assign m_chroma_index = chroma_index_reg;
    assign m_frame_last   = frame_last_reg;

endmodule

`default_nettype wire
